// File: src/assert_macros.svh
// Assertion macros shared by the decoder modules.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: src/rle8d_pkg.sv
// Types and constants of the RLE8 bitmap decoder.
// No dependencies; imported by every decoder module.
package rle8d_pkg;

    localparam int CODE_W    = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int ADDR_W    = 24;
    localparam int RUN_W     = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Second byte of an escape
    localparam logic [CODE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [CODE_W-1:0] ESC_END   = 8'd1;
    localparam logic [CODE_W-1:0] ESC_DELTA = 8'd2;

    typedef enum logic [1:0] {
        KIND_FILL    = 2'd0,
        KIND_LITERAL = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef struct packed {
        logic [CODE_W-1:0] code_byte;
        logic              restart;
    } t_item;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] address;
        logic [RUN_W-1:0]  run_length;
        logic [CODE_W-1:0] pixel_value;
        logic              last;
    } t_result;

    // Parse phase of the front end
    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_VALUE = 3'd1,
        PH_DX    = 3'd2,
        PH_DY    = 3'd3,
        PH_LIT   = 3'd4,
        PH_PAD   = 3'd5
    } t_phase;

    // Commands passed from front end to back end
    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_FILL  = 3'd1,
        OP_EOL   = 3'd2,
        OP_END   = 3'd3,
        OP_DELTA = 3'd4,
        OP_LIT   = 3'd5
    } t_op;

    typedef struct packed {
        t_op               op;
        logic              restart;   // clear position and end flag first
        logic [CODE_W-1:0] count;     // fill count, or delta x
        logic [CODE_W-1:0] value;     // pixel value, or delta y
        logic              lit_last;  // literal closes its packet
    } t_cmd;

    // Back end sequencer states
    typedef enum logic [2:0] {
        BS_IDLE  = 3'd0,
        BS_EXEC  = 3'd1,
        BS_DADD  = 3'd2,
        BS_MOD   = 3'd3,
        BS_EOLA  = 3'd4,
        BS_ADV   = 3'd5,
        BS_CHECK = 3'd6,
        BS_EMIT  = 3'd7
    } t_bstate;

endpackage

// File: src/rle8_bitmap_decoder_unit.sv
// RLE8 bitmap decoder top level: configuration registers, front end,
// command queue and back end. Depends on rle8d_pkg and all rle8d_* modules.
//
// Decodes an 8-bit run-length coded bitmap stream, one code byte per input
// item, into pixel writes against a linear buffer of image_width x
// image_height pixels. A count/value pair gives one fill-run result, each
// literal of an absolute-mode escape gives one literal-pixel result, and the
// end escape gives an end mark; the last result of an image has last set,
// and every write is clipped at the buffer size. Bytes after the end are
// swallowed silently until an item with restart set. The front end takes one
// byte per cycle whenever the four-entry command queue has room. The back
// end steps a fill or a literal through execute, advance and check, an end
// mark through execute and emit, a delta through a multiply by the width,
// then the add, advance and check, and an end-of-line through a row
// remainder formed one position bit per cycle, POS_W being the position
// width (25 bits at the default limits), then a round-up, advance and check.
// A result that finds the output register still full waits in the back end
// until the consumer takes the previous one. Results leave through
// a registered output that decouples the back end from the consumer.
// Configure the image size only while the decoder is idle.
module rle8_bitmap_decoder_unit
    import rle8d_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // code byte channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_item                i_in_item,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_result              o_out_result,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int QUEUE_DEPTH = 4;

    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_wdata;
    t_cmd q_rdata;

    // Configuration registers; raw values, clamping happens in the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(1);
            r_image_height <= CFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Front end: parse bytes, push one command per meaningful byte
    rle8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_wdata)
    );

    // Hold commands while the back end is busy on earlier ones
    rle8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Back end: advance the write position, clip, detect the end, emit
    rle8d_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_cmd          (q_rdata),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_result   (o_out_result)
    );

endmodule

// File: src/rle8d_queue.sv
// Small command queue between decoder front end and back end.
// Depends on rle8d_pkg (t_cmd) and assert_macros.svh.
`include "assert_macros.svh"

module rle8d_queue
    import rle8d_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop, "push into full queue")
    `ASSERT_NEVER(a_queue_underflow, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")

endmodule

// File: src/rle8d_front.sv
// Decoder front end: accepts code bytes, tracks the packet syntax and
// turns each meaningful byte into a command. Depends on rle8d_pkg.
module rle8d_front
    import rle8d_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_full,
    output logic  o_push,
    output t_cmd  o_cmd
);

    t_phase            r_phase,  n_phase;
    logic [CODE_W-1:0] r_count,  n_count;
    logic [CODE_W-1:0] r_dx,     n_dx;
    logic [CODE_W-1:0] r_left,   n_left;
    logic              r_odd,    n_odd;
    logic              accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        t_phase ph;
        ph      = i_item.restart ? PH_COUNT : r_phase;
        n_phase = ph;
        n_count = i_item.restart ? '0 : r_count;
        n_dx    = i_item.restart ? '0 : r_dx;
        n_left  = i_item.restart ? '0 : r_left;
        n_odd   = i_item.restart ? 1'b0 : r_odd;
        o_cmd.op       = OP_NOP;
        o_cmd.restart  = i_item.restart;
        o_cmd.count    = r_count;
        o_cmd.value    = i_item.code_byte;
        o_cmd.lit_last = 1'b0;
        unique case (ph)
            PH_COUNT: begin
                n_count = i_item.code_byte;
                n_phase = PH_VALUE;
            end
            PH_VALUE: begin
                n_phase = PH_COUNT;
                priority if (r_count != '0) begin
                    o_cmd.op = OP_FILL;
                end else if (i_item.code_byte == ESC_EOL) begin
                    o_cmd.op = OP_EOL;
                end else if (i_item.code_byte == ESC_END) begin
                    o_cmd.op = OP_END;
                end else if (i_item.code_byte == ESC_DELTA) begin
                    n_phase = PH_DX;
                end else begin
                    // absolute mode: literal count, pad after odd counts
                    n_left  = i_item.code_byte;
                    n_odd   = i_item.code_byte[0];
                    n_phase = PH_LIT;
                end
            end
            PH_DX: begin
                n_dx    = i_item.code_byte;
                n_phase = PH_DY;
            end
            PH_DY: begin
                o_cmd.op    = OP_DELTA;
                o_cmd.count = r_dx;
                n_phase     = PH_COUNT;
            end
            PH_LIT: begin
                o_cmd.op       = OP_LIT;
                o_cmd.lit_last = (r_left == 8'd1);
                n_left         = r_left - 1'b1;
                if (r_left == 8'd1) begin
                    n_phase = r_odd ? PH_PAD : PH_COUNT;
                end
            end
            PH_PAD: begin
                n_phase = PH_COUNT;
            end
            default: begin
                n_phase = PH_COUNT;
            end
        endcase
    end

    assign o_push = accept && ((o_cmd.op != OP_NOP) || i_item.restart);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT;
            r_count <= '0;
            r_dx    <= '0;
            r_left  <= '0;
            r_odd   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_dx    <= n_dx;
            r_left  <= n_left;
            r_odd   <= n_odd;
        end
    end

endmodule

// File: src/rle8d_back.sv
// Decoder back end: carries out commands against the write position,
// clips at the image size and drives the result register.
// Depends on rle8d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rle8d_back
    import rle8d_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_image_width,
    input  logic [CFG_W-1:0] i_image_height,
    input  t_cmd             i_cmd,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_result          o_out_result
);

    localparam int CFG_MAX  = (1 << CFG_W) - 1;
    localparam int EW_MAX   = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
    localparam int EH_MAX   = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
    localparam int WW       = $clog2(EW_MAX + 1);
    localparam int HW       = $clog2(EH_MAX + 1);
    localparam longint SIZE_MAX = longint'(EW_MAX) * longint'(EH_MAX);
    localparam longint AMT_MAX  = 255 * longint'(EW_MAX) + 255;
    localparam int SIZE_W   = $clog2(SIZE_MAX + 1);
    localparam int AMT_W    = $clog2(AMT_MAX + 1);
    localparam int POS_W    = $clog2(SIZE_MAX + AMT_MAX + 1);
    localparam int BIT_W    = $clog2(POS_W);

    t_bstate           r_state,  n_state;
    t_cmd              r_cmd,    n_cmd;
    logic [POS_W-1:0]  r_pos,    n_pos;
    logic              r_fin,    n_fin;
    logic [AMT_W-1:0]  r_amount, n_amount;
    logic [WW-1:0]     r_rem,    n_rem;
    logic [BIT_W-1:0]  r_bit,    n_bit;
    t_result           r_res,    n_res;
    logic              r_have,   n_have;
    logic              r_done,   n_done;
    logic              r_out_valid, n_out_valid;
    t_result           r_out,    n_out;

    logic [WW-1:0]     r_w_eff;
    logic [HW-1:0]     r_h_eff;
    logic [SIZE_W-1:0] r_size;

    logic [POS_W-1:0]  size_ext;
    logic [POS_W-1:0]  room;
    logic [POS_W-1:0]  amount_ext;
    logic              take_all;
    logic [POS_W-1:0]  adv_len;
    logic [POS_W-1:0]  adv_pos;
    logic              end_hit;
    logic [WW:0]       rem_shift;
    logic [WW-1:0]     rem_next;
    logic              out_free;

    // Clamp the configured dimensions and form the buffer size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff <= WW'(1);
            r_h_eff <= HW'(1);
            r_size  <= SIZE_W'(1);
        end else begin
            priority if (i_image_width == '0) begin
                r_w_eff <= WW'(1);
            end else if (i_image_width > CFG_W'(EW_MAX)) begin
                r_w_eff <= WW'(EW_MAX);
            end else begin
                r_w_eff <= WW'(i_image_width);
            end
            priority if (i_image_height == '0) begin
                r_h_eff <= HW'(1);
            end else if (i_image_height > CFG_W'(EH_MAX)) begin
                r_h_eff <= HW'(EH_MAX);
            end else begin
                r_h_eff <= HW'(i_image_height);
            end
            r_size <= SIZE_W'(r_w_eff) * SIZE_W'(r_h_eff);
        end
    end

    // Advance with clipping; a position already past the size grows freely
    assign size_ext   = POS_W'(r_size);
    assign room       = size_ext - r_pos;
    assign amount_ext = POS_W'(r_amount);
    assign take_all   = (size_ext < r_pos) || (amount_ext < room);
    assign adv_len    = take_all ? amount_ext : room;
    assign adv_pos    = take_all ? (r_pos + amount_ext) : size_ext;

    // Image ends once fewer than two pixels remain
    assign end_hit = ({1'b0, r_pos} + 1'b1) >= {1'b0, size_ext};

    // One remainder bit per cycle, most significant position bit first
    assign rem_shift = {r_rem, r_pos[r_bit]};
    assign rem_next  = (rem_shift >= {1'b0, r_w_eff}) ?
                       WW'(rem_shift - {1'b0, r_w_eff}) : WW'(rem_shift);

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        t_result v_res;
        logic    v_have;
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_fin       = r_fin;
        n_amount    = r_amount;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_res       = r_res;
        n_have      = r_have;
        n_done      = r_done;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        v_res       = r_res;
        v_have      = r_have;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    priority if (i_cmd.restart) begin
                        n_pos   = '0;
                        n_fin   = 1'b0;
                        n_state = BS_EXEC;
                    end else if (!r_fin) begin
                        n_state = BS_EXEC;
                    end
                    // drop commands after the end of the image
                end
            end
            BS_EXEC: begin
                n_have            = 1'b0;
                n_done            = 1'b0;
                n_res.address     = ADDR_W'(r_pos);
                n_res.run_length  = '0;
                n_res.pixel_value = r_cmd.value;
                n_res.last        = 1'b0;
                n_res.kind        = KIND_FILL;
                unique case (r_cmd.op)
                    OP_FILL: begin
                        n_amount = AMT_W'(r_cmd.count);
                        n_have   = 1'b1;
                        n_done   = 1'b1;
                        n_state  = BS_ADV;
                    end
                    OP_LIT: begin
                        n_amount   = AMT_W'(1);
                        n_res.kind = KIND_LITERAL;
                        n_have     = 1'b1;
                        n_done     = r_cmd.lit_last;
                        n_state    = BS_ADV;
                    end
                    OP_END: begin
                        n_res.kind        = KIND_END;
                        n_res.pixel_value = '0;
                        n_res.last        = 1'b1;
                        n_have            = 1'b1;
                        n_fin             = 1'b1;
                        n_state           = BS_EMIT;
                    end
                    OP_EOL: begin
                        n_rem   = '0;
                        n_bit   = BIT_W'(POS_W - 1);
                        n_done  = 1'b1;
                        n_state = BS_MOD;
                    end
                    OP_DELTA: begin
                        n_amount = AMT_W'(r_cmd.value) * AMT_W'(r_w_eff);
                        n_done   = 1'b1;
                        n_state  = BS_DADD;
                    end
                    default: begin
                        n_state = BS_IDLE;
                    end
                endcase
            end
            BS_DADD: begin
                n_amount = r_amount + AMT_W'(r_cmd.count);
                n_state  = BS_ADV;
            end
            BS_MOD: begin
                n_rem = rem_next;
                if (r_bit == '0) begin
                    n_state = BS_EOLA;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            BS_EOLA: begin
                // round up to the next row boundary unless already on one
                n_amount = (r_rem == '0) ? '0 : AMT_W'(r_w_eff) - AMT_W'(r_rem);
                n_state  = BS_ADV;
            end
            BS_ADV: begin
                n_pos            = adv_pos;
                n_res.run_length = RUN_W'(adv_len);
                n_state          = BS_CHECK;
            end
            BS_CHECK: begin
                if (r_done && end_hit) begin
                    n_fin = 1'b1;
                    if (r_have) begin
                        v_res.last = 1'b1;
                    end else begin
                        v_res.kind        = KIND_END;
                        v_res.address     = ADDR_W'(r_pos);
                        v_res.run_length  = '0;
                        v_res.pixel_value = '0;
                        v_res.last        = 1'b1;
                        v_have            = 1'b1;
                    end
                end
                n_res  = v_res;
                n_have = v_have;
                priority if (!v_have) begin
                    n_state = BS_IDLE;
                end else if (out_free) begin
                    n_out       = v_res;
                    n_out_valid = 1'b1;
                    n_have      = 1'b0;
                    n_state     = BS_IDLE;
                end else begin
                    n_state = BS_EMIT;
                end
            end
            BS_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_have      = 1'b0;
                    n_state     = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_pos       <= '0;
            r_fin       <= 1'b0;
            r_have      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_fin       <= n_fin;
            r_have      <= n_have;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_amount <= n_amount;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

    `ASSERT_CLK(a_rem_below_width, i_clk, i_rst_n, (r_state == BS_MOD) |-> (r_rem < r_w_eff), "row remainder reached the width")
    `ASSERT_CLK(a_end_has_result, i_clk, i_rst_n, $rose(r_fin) |-> r_have || $rose(r_out_valid) || (r_out_valid && r_out.last), "image ended without a final result")

endmodule

// File: tb/testbench.sv
// Self-checking bench for rle8_bitmap_decoder_unit: feeds coded bitmap bytes,
// predicts every pixel write and end mark in-house and compares field by field.
// Depends on rle8d_pkg and the decoder RTL; reads no files.
module testbench;
    import rle8d_pkg::*;

    localparam int MAX_W          = 4096;   // matches the default parameters
    localparam int MAX_H          = 4096;
    localparam int RESET_CYCLES   = 9;
    localparam int MAX_GAP        = 18;
    localparam int SETTLE_CYCLES  = 250;    // four queued end-of-line moves and more
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 2000;

    // first byte of an escape pair
    localparam logic [CODE_W-1:0] ESCAPE_MARK = 8'd0;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_item                in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_result              out_result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // decoder shadow: configuration and parse state
    logic [CFG_W-1:0]     cfg_width = 13'd1;
    logic [CFG_W-1:0]     cfg_height = 13'd1;
    t_phase               dec_phase = PH_COUNT;
    logic [7:0]           dec_count = '0;
    longint unsigned      dec_pos = 0;
    logic [7:0]           dec_dx = '0;
    logic [7:0]           dec_lits_left = '0;
    logic                 dec_lits_odd = 1'b0;
    bit                   dec_done = 1'b0;

    t_result              decoded_results[$];
    int unsigned          mismatch_count = 0;
    int unsigned          bytes_decoded = 0;
    int unsigned          stall_cycles = 0;
    bit                   restart_next = 1'b0;
    bit                   sender_idle_on = 1'b1;
    bit                   sink_idle_on = 1'b1;
    bit                   hold_results = 1'b0;

    rle8_bitmap_decoder_unit i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_item    (in_item),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_result (out_result),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    function automatic longint unsigned row_pixels();
        longint unsigned w;
        w = cfg_width;
        if (w == 0) w = 1;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic longint unsigned image_pixels();
        longint unsigned h;
        h = cfg_height;
        if (h == 0) h = 1;
        if (h > MAX_H) h = MAX_H;
        return row_pixels() * h;
    endfunction

    function automatic void clear_decoder();
        dec_phase     = PH_COUNT;
        dec_count     = '0;
        dec_pos       = 0;
        dec_dx        = '0;
        dec_lits_left = '0;
        dec_lits_odd  = 1'b0;
        dec_done      = 1'b0;
    endfunction

    // Move the write position forward, saturating at the buffer size.
    function automatic void advance_position(longint unsigned n);
        longint unsigned room;
        room = image_pixels() - dec_pos;
        dec_pos = (n >= room) ? image_pixels() : dec_pos + n;
    endfunction

    function automatic t_result end_mark();
        t_result r;
        r.kind        = KIND_END;
        r.address     = dec_pos[ADDR_W-1:0];
        r.run_length  = '0;
        r.pixel_value = '0;
        r.last        = 1'b1;
        return r;
    endfunction

    // Write n pixels at the current position, clipped at the buffer end.
    function automatic t_result pixel_write(t_kind kind, longint unsigned n,
                                            logic [7:0] value);
        t_result         r;
        longint unsigned room;
        room          = image_pixels() - dec_pos;
        r.kind        = kind;
        r.address     = dec_pos[ADDR_W-1:0];
        r.run_length  = (n < room) ? n[RUN_W-1:0] : room[RUN_W-1:0];
        r.pixel_value = value;
        r.last        = 1'b0;
        advance_position(n);
        return r;
    endfunction

    // Take one code byte; return 1 when it produces a result.
    function automatic bit decode_code_byte(t_item item, output t_result r);
        logic [7:0]      b;
        bit              has_result;
        bit              packet_done;
        longint unsigned rem;
        b           = item.code_byte;
        has_result  = 1'b0;
        packet_done = 1'b0;
        r           = '0;
        if (item.restart) clear_decoder();
        if (dec_done) return 1'b0;
        case (dec_phase)
            PH_COUNT: begin
                dec_count = b;
                dec_phase = PH_VALUE;
            end
            PH_VALUE: begin
                dec_phase = PH_COUNT;
                if (dec_count != 0) begin
                    r = pixel_write(KIND_FILL, dec_count, b);
                    has_result  = 1'b1;
                    packet_done = 1'b1;
                end else if (b == ESC_EOL) begin
                    // round up to the next row start; stay put on a boundary
                    rem = dec_pos % row_pixels();
                    if (rem != 0) advance_position(row_pixels() - rem);
                    packet_done = 1'b1;
                end else if (b == ESC_END) begin
                    r = end_mark();
                    dec_done = 1'b1;
                    return 1'b1;
                end else if (b == ESC_DELTA) begin
                    dec_phase = PH_DX;
                end else begin
                    dec_lits_left = b;
                    dec_lits_odd  = b[0];
                    dec_phase     = PH_LIT;
                end
            end
            PH_DX: begin
                dec_dx    = b;
                dec_phase = PH_DY;
            end
            PH_DY: begin
                advance_position(longint'(b) * row_pixels() + dec_dx);
                dec_phase   = PH_COUNT;
                packet_done = 1'b1;
            end
            PH_LIT: begin
                r = pixel_write(KIND_LITERAL, 1, b);
                has_result    = 1'b1;
                dec_lits_left = dec_lits_left - 8'd1;
                if (dec_lits_left == 0) begin
                    dec_phase   = dec_lits_odd ? PH_PAD : PH_COUNT;
                    packet_done = 1'b1;
                end
            end
            default: dec_phase = PH_COUNT;
        endcase
        // end by position: flag the packet's result or emit an end mark
        if (packet_done && dec_pos + 2 > image_pixels()) begin
            dec_done = 1'b1;
            if (has_result) begin
                r.last = 1'b1;
            end else begin
                r = end_mark();
                has_result = 1'b1;
            end
        end
        return has_result;
    endfunction

    // ------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------

    // Offer one byte after a random pause; predict once it is taken.
    task automatic send_byte(logic [7:0] code, logic restart);
        int unsigned gap;
        t_result     r;
        bit          skipped;
        gap = sender_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  = '{code_byte: code, restart: restart | restart_next};
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        restart_next = 1'b0;
        skipped = dec_done && !in_item.restart;
        if (decode_code_byte(in_item, r)) decoded_results.push_back(r);
        if (!skipped) bytes_decoded++;
    endtask

    task automatic send_fill(logic [7:0] count, logic [7:0] value);
        send_byte(count, 1'b0);
        send_byte(value, 1'b0);
    endtask

    task automatic send_eol();
        send_byte(ESCAPE_MARK, 1'b0);
        send_byte(ESC_EOL, 1'b0);
    endtask

    task automatic send_image_end();
        send_byte(ESCAPE_MARK, 1'b0);
        send_byte(ESC_END, 1'b0);
    endtask

    task automatic send_delta(logic [7:0] dx, logic [7:0] dy);
        send_byte(ESCAPE_MARK, 1'b0);
        send_byte(ESC_DELTA, 1'b0);
        send_byte(dx, 1'b0);
        send_byte(dy, 1'b0);
    endtask

    // Absolute run of n random pixels, padded to an even byte count.
    task automatic send_literals(logic [7:0] n);
        send_byte(ESCAPE_MARK, 1'b0);
        send_byte(n, 1'b0);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
        if (n[0]) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Drop valid, wait for every predicted result, then let the back end
    // finish any silent work (end-of-line and delta moves).
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (decoded_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_image_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        wait_for_drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_wdata = w;
        @(negedge clk);
        cfg_index = CFG_IMAGE_HEIGHT;
        cfg_wdata = h;
        @(negedge clk);
        cfg_we     = 1'b0;
        cfg_width  = w;
        cfg_height = h;
        // never carry a position from the old size into the new one
        restart_next = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------

    initial begin : result_sink
        int unsigned gap;
        forever begin
            @(negedge clk);
            if (hold_results) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_results = 1'b0;
            end
            if ($urandom_range(0, 39) == 0) sink_idle_on = !sink_idle_on;
            gap = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap != 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic void check_field(string field, logic [31:0] want,
                                        logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (decoded_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0d addr %0h",
                         $time, out_result.kind, out_result.address);
                mismatch_count++;
            end else begin
                want = decoded_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(out_result.kind));
                check_field("address", 32'(want.address), 32'(out_result.address));
                check_field("run_length", 32'(want.run_length),
                            32'(out_result.run_length));
                check_field("pixel_value", 32'(want.pixel_value),
                            32'(out_result.pixel_value));
                check_field("last", 32'(want.last), 32'(out_result.last));
            end
        end
    end

    // Abort when neither channel moves for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the image is 1x1: the first packet ends it, clipped.
    task automatic test_reset_state();
        send_fill(8'd3, 8'hA5);
        send_byte(8'h5A, 1'b0);        // after the end: swallowed
    endtask

    // Zero sizes act as 1; oversize values act as the maxima.
    task automatic test_register_limits();
        set_image_size(13'd0, 13'd0);
        send_eol();                     // no write, so an end mark follows
        set_image_size(13'h1FFF, 13'h1FFF);
        send_fill(8'd255, 8'hFF);
        send_delta(8'd255, 8'd255);
        send_eol();
        send_image_end();
    endtask

    // A run fits the buffer, then literals past the buffer end shrink to zero length.
    task automatic test_clipping();
        set_image_size(13'd4, 13'd2);
        send_fill(8'd5, 8'h00);
        send_literals(8'd5);            // last literal closes the image, pad dropped
    endtask

    // Every escape: row boundary, mid-row end of line, delta, even and odd
    // literal runs, end by position and explicit end.
    task automatic test_escapes();
        set_image_size(13'd16, 13'd4);
        send_fill(8'd16, 8'h80);
        send_eol();
        send_fill(8'd3, 8'h01);
        send_eol();
        send_delta(8'd3, 8'd1);
        send_literals(8'd4);
        send_literals(8'd3);
        send_eol();                     // reaches the end of the buffer
        restart_next = 1'b1;
        send_fill(8'd1, 8'h7F);
        send_image_end();
    endtask

    // Hold results back while bytes keep coming, so the input stalls.
    task automatic test_backpressure();
        set_image_size(13'd4096, 13'd4096);
        sender_idle_on = 1'b0;
        hold_results   = 1'b1;
        restart_next   = 1'b1;
        repeat (40) send_fill(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
        send_image_end();
        sender_idle_on = 1'b1;
    endtask

    // One image of random well-formed packets with some noise mixed in.
    task automatic random_image();
        int unsigned packets;
        int unsigned choice;
        sender_idle_on = ($urandom_range(0, 3) != 0);
        restart_next   = 1'b1;
        packets        = $urandom_range(1, 40);
        for (int i = 0; i < packets; i++) begin
            if (dec_done && !restart_next) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                break;
            end
            choice = $urandom_range(0, 99);
            if (choice < 40) begin
                send_fill(8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                         : $urandom_range(1, 16)),
                          8'($urandom_range(0, 255)));
            end else if (choice < 60) begin
                send_literals(8'(($urandom_range(0, 7) == 0) ? $urandom_range(3, 255)
                                                             : $urandom_range(3, 12)));
            end else if (choice < 70) begin
                send_eol();
            end else if (choice < 80) begin
                send_delta(8'($urandom_range(0, 255)),
                           8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 2)));
            end else if (choice < 84) begin
                send_image_end();
            end else begin
                // stray byte: misaligns the stream, sometimes restarts it
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
        end
    endtask

    task automatic test_random_images();
        int unsigned first;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        first = bytes_decoded;
        while (bytes_decoded - first < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    w = 13'd0;
                    h = CFG_W'($urandom_range(0, 3));
                end
                1: begin
                    w = CFG_W'($urandom_range(MAX_W, 13'h1FFF));
                    h = CFG_W'($urandom_range(MAX_H, 13'h1FFF));
                end
                2: begin
                    w = CFG_W'($urandom_range(1, 4));
                    h = CFG_W'($urandom_range(0, 4));
                end
                default: begin
                    w = CFG_W'($urandom_range(1, 64));
                    h = CFG_W'($urandom_range(1, 16));
                end
            endcase
            set_image_size(w, h);
            repeat ($urandom_range(3, 8)) random_image();
        end
    endtask

    initial begin
        clear_decoder();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_register_limits();
        test_clipping();
        test_escapes();
        test_backpressure();
        test_random_images();

        wait_for_drain();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/rle8d_pkg.sv
src/rle8d_queue.sv
src/rle8d_front.sv
src/rle8d_back.sv
src/rle8_bitmap_decoder_unit.sv
tb/testbench.sv
